FILE: hw/rtl/vertex_rotate_project_core_defines.svh
// Assertion macros for the vertex rotate/project core.
// Used by files that assert; expects i_clk and i_rst_n in scope.
`ifndef VERTEX_ROTATE_PROJECT_CORE_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// checked only while out of reset
`define VRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define VRP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define VRP_ASSERT(lbl, prop, msg)
`define VRP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/vrp_pkg.sv
// Shared types and constants for the vertex rotate/project core.
// No dependencies; used by vrp_div_stage and vertex_rotate_project_core.
package vrp_pkg;

    // screen and projection constants
    localparam int VRP_SCREEN_SIZE  = 256;
    localparam int VRP_SCALE_DIV    = 3;
    localparam int VRP_DEPTH_OFFSET = 2;

    // fixed-point formats: trig Q1.14, vertex Q4.12
    localparam int VRP_TRIG_FRAC = 14;
    localparam int VRP_VERT_FRAC = 12;

    // depth after both rotations plus bias (signed), and its positive range
    localparam int VRP_DEPTH_W = 51;
    localparam int VRP_DEN_W   = 50;
    // numerator width before the scale factor is applied
    localparam int VRP_NUM_BASE_W = 52;

    localparam logic [VRP_DEPTH_W-1:0] VRP_DEPTH_BIAS =
        VRP_DEPTH_W'(VRP_DEPTH_OFFSET) << (VRP_VERT_FRAC + 2 * VRP_TRIG_FRAC);

    localparam logic signed [15:0] VRP_TRIG_ONE = 16'sh4000;

    // divider widths for the default screen size
    localparam int VRP_DEF_QUO_W = $clog2(VRP_SCREEN_SIZE + 1) + 1;
    localparam int VRP_DEF_REM_W =
        VRP_NUM_BASE_W + $clog2(VRP_SCREEN_SIZE / VRP_SCALE_DIV + 1);

    // configuration register map
    typedef enum logic [2:0] {
        REG_YAW_COS   = 3'd0,
        REG_YAW_SIN   = 3'd1,
        REG_PITCH_COS = 3'd2,
        REG_PITCH_SIN = 3'd3
    } t_vrp_reg;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_z;
    } t_vrp_vertex;

    typedef struct packed {
        logic [7:0] pixel_col;
        logic [7:0] pixel_row;
        logic       depth_invalid;
    } t_vrp_pixel;

    // per-item status carried through the divider
    typedef struct packed {
        logic inv;
        logic neg_x;
        logic neg_y;
    } t_vrp_flags;

endpackage

FILE: hw/rtl/vrp_div_stage.sv
// One restoring-division step for both screen axes, registered.
// Depends on vrp_pkg for the status struct and default widths.
module vrp_div_stage #(
    parameter int REM_W = vrp_pkg::VRP_DEF_REM_W,
    parameter int DEN_W = vrp_pkg::VRP_DEN_W,
    parameter int QUO_W = vrp_pkg::VRP_DEF_QUO_W,
    parameter int SHIFT = 0
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [DEN_W-1:0]        i_den,
    input  vrp_pkg::t_vrp_flags     i_flags,
    input  logic [REM_W-1:0]        i_rem_x,
    input  logic [REM_W-1:0]        i_rem_y,
    input  logic [QUO_W-1:0]        i_quo_x,
    input  logic [QUO_W-1:0]        i_quo_y,
    output logic [DEN_W-1:0]        o_den,
    output vrp_pkg::t_vrp_flags     o_flags,
    output logic [REM_W-1:0]        o_rem_x,
    output logic [REM_W-1:0]        o_rem_y,
    output logic [QUO_W-1:0]        o_quo_x,
    output logic [QUO_W-1:0]        o_quo_y
);

    logic [REM_W-1:0]    w_trial;
    logic                w_ge_x;
    logic                w_ge_y;
    logic [REM_W-1:0]    n_rem_x;
    logic [REM_W-1:0]    n_rem_y;
    logic [QUO_W-1:0]    n_quo_x;
    logic [QUO_W-1:0]    n_quo_y;

    logic [DEN_W-1:0]    r_den;
    vrp_pkg::t_vrp_flags r_flags;
    logic [REM_W-1:0]    r_rem_x;
    logic [REM_W-1:0]    r_rem_y;
    logic [QUO_W-1:0]    r_quo_x;
    logic [QUO_W-1:0]    r_quo_y;

    // divisor aligned to this quotient bit
    assign w_trial = REM_W'(i_den) << SHIFT;

    // compare and conditionally subtract, per axis
    always_comb begin
        w_ge_x  = (i_rem_x >= w_trial);
        w_ge_y  = (i_rem_y >= w_trial);
        n_rem_x = w_ge_x ? (i_rem_x - w_trial) : i_rem_x;
        n_rem_y = w_ge_y ? (i_rem_y - w_trial) : i_rem_y;
        n_quo_x = i_quo_x | (QUO_W'(w_ge_x) << SHIFT);
        n_quo_y = i_quo_y | (QUO_W'(w_ge_y) << SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den   <= i_den;
            r_flags <= i_flags;
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_quo_x <= n_quo_x;
            r_quo_y <= n_quo_y;
        end
    end

    assign o_den   = r_den;
    assign o_flags = r_flags;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_quo_x = r_quo_x;
    assign o_quo_y = r_quo_y;

endmodule

FILE: hw/rtl/vertex_rotate_project_core.sv
// Vertex rotate/project core. Takes one Q4.12 vertex per beat, rotates it about
// Y then X with the sine/cosine registers, offsets depth by 2.0 and projects it
// onto a SCREEN_SIZE square, floored and clamped. One vertex is accepted every
// cycle while the output is not stalled. The pipeline is three multiply stages,
// a magnitude stage, one restoring-division stage per quotient bit, and the
// output register. A stall while a pixel beat waits at the output freezes the
// whole pipeline; nothing is dropped or repeated. Registers are written at any
// time through the config channel (always ready) but should only change while
// the pipeline is empty. Depth at or below zero gives depth_invalid with zero
// coordinates. Depends on vrp_pkg, vrp_div_stage and the defines header.
`include "vertex_rotate_project_core_defines.svh"

module vertex_rotate_project_core #(
    parameter int SCREEN_SIZE = vrp_pkg::VRP_SCREEN_SIZE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // vertex channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  vrp_pkg::t_vrp_vertex i_in_data,
    // pixel channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output vrp_pkg::t_vrp_pixel  o_out_data,
    // config channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    localparam int S2    = SCREEN_SIZE / 2;
    localparam int S3    = SCREEN_SIZE / vrp_pkg::VRP_SCALE_DIV;
    localparam int S3W   = $clog2(S3 + 1);
    localparam int NW    = vrp_pkg::VRP_NUM_BASE_W + S3W;
    localparam int DW    = vrp_pkg::VRP_DEN_W;
    localparam int QW    = $clog2(SCREEN_SIZE + 1);
    localparam int QB    = QW + 1;
    localparam int RW    = (NW > DW + QW) ? NW : DW + QW;
    localparam int CW    = QB + 2;
    localparam int NST   = 4 + QB + 1;
    localparam int FR    = vrp_pkg::VRP_TRIG_FRAC;

    localparam logic signed [S3W:0]   S3_S  = (S3W + 1)'(S3);
    localparam logic signed [CW-1:0]  S2_C  = CW'(S2);
    localparam logic signed [CW-1:0]  MAX_C = CW'(SCREEN_SIZE - 1);

    // ------------------------------------------------------------------
    // configuration registers
    logic signed [15:0] r_yaw_cos, r_yaw_sin, r_pitch_cos, r_pitch_sin;
    logic signed [15:0] n_yaw_cos, n_yaw_sin, n_pitch_cos, n_pitch_sin;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_yaw_cos   = r_yaw_cos;
        n_yaw_sin   = r_yaw_sin;
        n_pitch_cos = r_pitch_cos;
        n_pitch_sin = r_pitch_sin;
        if (i_cfg_valid) begin
            unique case (vrp_pkg::t_vrp_reg'(i_cfg_index))
                vrp_pkg::REG_YAW_COS:   n_yaw_cos   = i_cfg_data;
                vrp_pkg::REG_YAW_SIN:   n_yaw_sin   = i_cfg_data;
                vrp_pkg::REG_PITCH_COS: n_pitch_cos = i_cfg_data;
                vrp_pkg::REG_PITCH_SIN: n_pitch_sin = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_cos   <= vrp_pkg::VRP_TRIG_ONE;
            r_yaw_sin   <= '0;
            r_pitch_cos <= vrp_pkg::VRP_TRIG_ONE;
            r_pitch_sin <= '0;
        end else begin
            r_yaw_cos   <= n_yaw_cos;
            r_yaw_sin   <= n_yaw_sin;
            r_pitch_cos <= n_pitch_cos;
            r_pitch_sin <= n_pitch_sin;
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: whole pipe advances unless the output beat is stuck
    logic           w_en;
    logic [NST-1:0] r_valid;

    assign w_en       = !r_valid[NST-1] || !i_out_stall;
    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[NST-2:0], i_in_valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: rotation about Y (Q.26), plus y products for stage 2
    logic signed [15:0] w_x, w_y, w_z;
    logic signed [31:0] w_p_xcy, w_p_zsy, w_p_zcy, w_p_xsy, w_p_ycp, w_p_ysp;
    logic signed [32:0] n_s1_x1, n_s1_z1;
    logic signed [32:0] r_s1_x1, r_s1_z1;
    logic signed [31:0] r_s1_ycp, r_s1_ysp;

    assign w_x = i_in_data.vertex_x;
    assign w_y = i_in_data.vertex_y;
    assign w_z = i_in_data.vertex_z;

    assign w_p_xcy = w_x * r_yaw_cos;
    assign w_p_zsy = w_z * r_yaw_sin;
    assign w_p_zcy = w_z * r_yaw_cos;
    assign w_p_xsy = w_x * r_yaw_sin;
    assign w_p_ycp = w_y * r_pitch_cos;
    assign w_p_ysp = w_y * r_pitch_sin;

    assign n_s1_x1 = {w_p_xcy[31], w_p_xcy} - {w_p_zsy[31], w_p_zsy};
    assign n_s1_z1 = {w_p_zcy[31], w_p_zcy} + {w_p_xsy[31], w_p_xsy};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_x1  <= n_s1_x1;
            r_s1_z1  <= n_s1_z1;
            r_s1_ycp <= w_p_ycp;
            r_s1_ysp <= w_p_ysp;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: rotation about X (Q.40)
    logic signed [48:0] w_p_z1sp, w_p_z1cp;
    logic signed [49:0] n_s2_y2, n_s2_z2;
    logic signed [49:0] r_s2_y2, r_s2_z2;
    logic signed [32:0] r_s2_x1;

    assign w_p_z1sp = r_s1_z1 * r_pitch_sin;
    assign w_p_z1cp = r_s1_z1 * r_pitch_cos;

    assign n_s2_y2 = {{4{r_s1_ycp[31]}}, r_s1_ycp, {FR{1'b0}}}
                   - {w_p_z1sp[48], w_p_z1sp};
    assign n_s2_z2 = {w_p_z1cp[48], w_p_z1cp}
                   + {{4{r_s1_ysp[31]}}, r_s1_ysp, {FR{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_x1 <= r_s1_x1;
            r_s2_y2 <= n_s2_y2;
            r_s2_z2 <= n_s2_z2;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: biased depth, scaled numerators (y negated for screen rows)
    logic signed [vrp_pkg::VRP_DEPTH_W-1:0] w_depth;
    logic signed [33+S3W:0]                 w_p_x1s3;
    logic signed [50+S3W:0]                 w_p_y2s3;
    logic signed [NW-1:0]                   n_s3_nx, n_s3_ny;
    logic signed [NW-1:0]                   r_s3_nx, r_s3_ny;
    logic [DW-1:0]                          r_s3_den;
    logic                                   r_s3_inv;

    assign w_depth  = {r_s2_z2[49], r_s2_z2} + vrp_pkg::VRP_DEPTH_BIAS;
    assign w_p_x1s3 = r_s2_x1 * S3_S;
    assign w_p_y2s3 = r_s2_y2 * S3_S;
    assign n_s3_nx  = {{4{w_p_x1s3[33+S3W]}}, w_p_x1s3, {FR{1'b0}}};
    assign n_s3_ny  = -{w_p_y2s3[50+S3W], w_p_y2s3};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_nx  <= n_s3_nx;
            r_s3_ny  <= n_s3_ny;
            r_s3_den <= w_depth[DW-1:0];
            r_s3_inv <= w_depth[vrp_pkg::VRP_DEPTH_W-1] || (w_depth == '0);
        end
    end

    // ------------------------------------------------------------------
    // stage 4: dividend magnitude; a negative numerator is biased by d-1
    // so that the unsigned quotient is the ceiling and its negation the floor
    logic [NW-1:0]       w_den_ext;
    logic [NW-1:0]       w_mag_x, w_mag_y;
    vrp_pkg::t_vrp_flags n_s4_flags;
    logic [RW-1:0]       r_s4_rem_x, r_s4_rem_y;
    logic [DW-1:0]       r_s4_den;
    vrp_pkg::t_vrp_flags r_s4_flags;

    assign w_den_ext = NW'(r_s3_den);

    always_comb begin
        w_mag_x = r_s3_nx[NW-1] ? ((~r_s3_nx) + w_den_ext) : r_s3_nx;
        w_mag_y = r_s3_ny[NW-1] ? ((~r_s3_ny) + w_den_ext) : r_s3_ny;
        n_s4_flags.inv   = r_s3_inv;
        n_s4_flags.neg_x = r_s3_nx[NW-1];
        n_s4_flags.neg_y = r_s3_ny[NW-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_rem_x <= RW'(w_mag_x);
            r_s4_rem_y <= RW'(w_mag_y);
            r_s4_den   <= r_s3_den;
            r_s4_flags <= n_s4_flags;
        end
    end

    // ------------------------------------------------------------------
    // divider: one quotient bit per stage, MSB first
    logic [RW-1:0]       w_rem_x [QB+1];
    logic [RW-1:0]       w_rem_y [QB+1];
    logic [QB-1:0]       w_quo_x [QB+1];
    logic [QB-1:0]       w_quo_y [QB+1];
    logic [DW-1:0]       w_den   [QB+1];
    vrp_pkg::t_vrp_flags w_flags [QB+1];

    assign w_rem_x[0] = r_s4_rem_x;
    assign w_rem_y[0] = r_s4_rem_y;
    assign w_quo_x[0] = '0;
    assign w_quo_y[0] = '0;
    assign w_den[0]   = r_s4_den;
    assign w_flags[0] = r_s4_flags;

    for (genvar g = 0; g < QB; g++) begin : g_div
        vrp_div_stage #(
            .REM_W (RW),
            .DEN_W (DW),
            .QUO_W (QB),
            .SHIFT (QB - 1 - g)
        ) u_div_stage (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_den   (w_den[g]),
            .i_flags (w_flags[g]),
            .i_rem_x (w_rem_x[g]),
            .i_rem_y (w_rem_y[g]),
            .i_quo_x (w_quo_x[g]),
            .i_quo_y (w_quo_y[g]),
            .o_den   (w_den[g+1]),
            .o_flags (w_flags[g+1]),
            .o_rem_x (w_rem_x[g+1]),
            .o_rem_y (w_rem_y[g+1]),
            .o_quo_x (w_quo_x[g+1]),
            .o_quo_y (w_quo_y[g+1])
        );
    end

    // ------------------------------------------------------------------
    // output: recenter, clamp to the screen, register the beat
    logic signed [CW-1:0] w_qx, w_qy, w_cx, w_cy, w_clx, w_cly;
    vrp_pkg::t_vrp_pixel  n_out;
    vrp_pkg::t_vrp_pixel  r_out;

    assign w_qx = $signed({2'b00, w_quo_x[QB]});
    assign w_qy = $signed({2'b00, w_quo_y[QB]});

    always_comb begin
        w_cx = w_flags[QB].neg_x ? (S2_C - w_qx) : (S2_C + w_qx);
        w_cy = w_flags[QB].neg_y ? (S2_C - w_qy) : (S2_C + w_qy);

        if (w_cx < 0)          w_clx = '0;
        else if (w_cx > MAX_C) w_clx = MAX_C;
        else                   w_clx = w_cx;

        if (w_cy < 0)          w_cly = '0;
        else if (w_cy > MAX_C) w_cly = MAX_C;
        else                   w_cly = w_cy;

        n_out.depth_invalid = w_flags[QB].inv;
        n_out.pixel_col     = w_flags[QB].inv ? 8'd0 : w_clx[7:0];
        n_out.pixel_row     = w_flags[QB].inv ? 8'd0 : w_cly[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_valid[NST-1];
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // assertions
    `VRP_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid, "pixel beat right after reset")
    `VRP_ASSERT(a_inv_zero, o_out_valid && o_out_data.depth_invalid |-> (o_out_data.pixel_col == 8'd0 && o_out_data.pixel_row == 8'd0), "invalid depth with nonzero coordinates")
    `VRP_ASSERT(a_on_screen, o_out_valid && (SCREEN_SIZE <= 256) |-> (32'(o_out_data.pixel_col) <= SCREEN_SIZE - 1 && 32'(o_out_data.pixel_row) <= SCREEN_SIZE - 1), "coordinate beyond screen edge")
    `VRP_ASSERT(a_freeze, o_out_valid && i_out_stall |=> $stable(r_valid), "pipeline moved while output stalled")

endmodule
